// ===== rtl/swfd_pkg.sv =====
// Package for the sync word frame deframer: widths, reset values, state and result types.
`default_nettype none
package swfd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CountW     = 4;
  localparam int unsigned CfgIdxW    = 1;

  localparam logic [WordW-1:0]  SyncWordReset     = 32'h1234_5678;
  localparam logic [CountW-1:0] PayloadWordsReset = 4'd9;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_WORD     = 1'b0,
    CFG_PAYLOAD_WORDS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic              in_frame;
    logic [23:0]       sync_window;
    logic [1:0]        window_fill;
    logic [1:0]        byte_in_word;
    logic [CountW-1:0] word_count;
    logic [23:0]       partial_word;
  } state_t;

  typedef struct packed {
    logic              word_valid;
    logic [CountW-1:0] word_index;
    logic [WordW-1:0]  word_value;
    logic              sync_found;
    logic              frame_done;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/swfd_step.sv =====
// Next-state and result logic for one received byte of the deframer.
`default_nettype none
module swfd_step import swfd_pkg::*; (
  input  state_t            st_i,
  input  logic [ByteW-1:0]  rx_byte_i,
  input  logic [WordW-1:0]  sync_word_i,
  input  logic [CountW-1:0] payload_words_i,
  output state_t            st_o,
  output result_t           res_o
);

  logic [WordW-1:0] shifted_window;
  logic [WordW-1:0] shifted_word;
  logic             last_word;

  assign shifted_window = {st_i.sync_window, rx_byte_i};
  assign shifted_word   = {st_i.partial_word, rx_byte_i};
  assign last_word      = ({1'b0, st_i.word_count} + 5'd1) >= {1'b0, payload_words_i};

  always_comb begin
    st_o  = st_i;
    res_o = '0;
    priority if (!st_i.in_frame && st_i.window_fill != 2'd3) begin
      st_o.sync_window = shifted_window[23:0];
      st_o.window_fill = st_i.window_fill + 2'd1;
    end else if (!st_i.in_frame) begin
      st_o.sync_window = shifted_window[23:0];
      if (shifted_window == sync_word_i) begin
        res_o.sync_found  = 1'b1;
        st_o.in_frame     = 1'b1;
        st_o.byte_in_word = 2'd0;
        st_o.word_count   = '0;
        st_o.partial_word = '0;
      end
    end else if (st_i.byte_in_word != 2'd3) begin
      st_o.partial_word = shifted_word[23:0];
      st_o.byte_in_word = st_i.byte_in_word + 2'd1;
    end else begin
      res_o.word_valid  = 1'b1;
      res_o.word_index  = st_i.word_count;
      res_o.word_value  = shifted_word;
      st_o.byte_in_word = 2'd0;
      st_o.partial_word = '0;
      if (last_word) begin
        res_o.frame_done = 1'b1;
        st_o.in_frame    = 1'b0;
        st_o.word_count  = '0;
        st_o.window_fill = 2'd0;
        st_o.sync_window = '0;
      end else begin
        st_o.word_count = st_i.word_count + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sync_word_frame_deframer.sv =====
// Sync word frame deframer top level: input register, step logic, result register.
// An accepted byte is held in the input register; its result then goes to the result register and out_valid_o.
// Throughput: one byte per cycle while the result register is not stalled; the state register takes swfd_step's output.
// A stalled result register stalls the input register, which then stalls the input.
// Reset (rst_ni low, asynchronous): hunting, empty window, config at its reset values.
`default_nettype none
module sync_word_frame_deframer import swfd_pkg::*; (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire  [CfgIdxW-1:0] cfg_idx_i,
  input  wire  [WordW-1:0]   cfg_data_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire  [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic               word_valid_o,
  output logic [CountW-1:0]  word_index_o,
  output logic [WordW-1:0]   word_value_o,
  output logic               sync_found_o,
  output logic               frame_done_o
);

  logic [WordW-1:0]  sync_word_q;
  logic [CountW-1:0] payload_words_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  byte_q;
  logic              out_valid_q;
  result_t           res_q;
  result_t           res_d;
  state_t            state_q;
  state_t            state_d;
  logic              advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_word_q     <= SyncWordReset;
      payload_words_q <= PayloadWordsReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYNC_WORD:     sync_word_q     <= cfg_data_i;
        CFG_PAYLOAD_WORDS: payload_words_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      byte_q <= rx_byte_i;
    end
  end

  swfd_step u_step (
    .st_i            (state_q),
    .rx_byte_i       (byte_q),
    .sync_word_i     (sync_word_q),
    .payload_words_i (payload_words_q),
    .st_o            (state_d),
    .res_o           (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
      if (in_valid_q) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_valid_o = res_q.word_valid;
  assign word_index_o = res_q.word_index;
  assign word_value_o = res_q.word_value;
  assign sync_found_o = res_q.sync_found;
  assign frame_done_o = res_q.frame_done;

`ifndef SYNTHESIS
  a_done_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.frame_done |-> res_q.word_valid && !res_q.sync_found)
    else $error("frame done without a completed word");

  a_hunt_counters_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.in_frame |-> state_q.byte_in_word == 2'd0 && state_q.word_count == '0)
    else $error("word counters not clear while hunting");

  a_sync_enters_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_valid_q && res_d.sync_found |=> state_q.in_frame)
    else $error("sync match did not start a frame");
`endif

endmodule
`default_nettype wire

// ===== tb/deframe_check_pkg.sv =====
// Expected-word tracker for the sync word frame deframer testbench.
`timescale 1ns / 1ps
package deframe_check_pkg;
  import swfd_pkg::*;

  class deframe_tracker;
    logic [WordW-1:0]  sync_word;
    logic [CountW-1:0] words_per_frame;
    state_t            st;
    result_t           expected_words[$];
    int                mismatches;

    function new();
      sync_word       = SyncWordReset;
      words_per_frame = PayloadWordsReset;
      st              = '0;
      mismatches      = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [WordW-1:0] data);
      case (idx)
        CFG_SYNC_WORD:     sync_word = data;
        CFG_PAYLOAD_WORDS: words_per_frame = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [ByteW-1:0] b);
      result_t          r;
      logic [WordW-1:0] cand;
      r = '0;
      if (!st.in_frame) begin
        if (st.window_fill < 2'd3) begin
          st.sync_window = {st.sync_window[15:0], b};
          st.window_fill = st.window_fill + 2'd1;
        end else begin
          cand = {st.sync_window, b};
          st.sync_window = cand[23:0];
          if (cand == sync_word) begin
            r.sync_found    = 1'b1;
            st.in_frame     = 1'b1;
            st.byte_in_word = '0;
            st.word_count   = '0;
            st.partial_word = '0;
          end
        end
      end else if (st.byte_in_word < 2'd3) begin
        st.partial_word = {st.partial_word[15:0], b};
        st.byte_in_word = st.byte_in_word + 2'd1;
      end else begin
        r.word_valid    = 1'b1;
        r.word_index    = st.word_count;
        r.word_value    = {st.partial_word, b};
        st.byte_in_word = '0;
        st.partial_word = '0;
        if (int'(st.word_count) + 1 >= int'(words_per_frame)) begin
          r.frame_done   = 1'b1;
          st.in_frame    = 1'b0;
          st.word_count  = '0;
          st.window_fill = '0;
          st.sync_window = '0;
        end else begin
          st.word_count = st.word_count + 1'b1;
        end
      end
      expected_words.push_back(r);
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (want !== got) begin
        $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $display("%0t result with no byte pending: expected none, got %0h", $time, got);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("word_valid", WordW'(want.word_valid), WordW'(got.word_valid));
      compare_field("word_index", WordW'(want.word_index), WordW'(got.word_index));
      compare_field("word_value", want.word_value, got.word_value);
      compare_field("sync_found", WordW'(want.sync_found), WordW'(got.sync_found));
      compare_field("frame_done", WordW'(want.frame_done), WordW'(got.frame_done));
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// Top-level testbench for the sync word frame deframer: stimulus, stalls and checking.
`timescale 1ns / 1ps
module tb_top;
  import swfd_pkg::*;
  import deframe_check_pkg::*;

  localparam int IdleLimit  = 2000;
  localparam int ByteTarget = 1275;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [WordW-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               word_valid_o;
  logic [CountW-1:0]  word_index_o;
  logic [WordW-1:0]   word_value_o;
  logic               sync_found_o;
  logic               frame_done_o;

  deframe_tracker tracker = new();
  int             burst_left = 0;
  int             bytes_sent = 0;
  logic [9:0]     stall_tick = '0;

  sync_word_frame_deframer dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .word_valid_o,
    .word_index_o,
    .word_value_o,
    .sync_found_o,
    .frame_done_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1'b1;
    case (stall_tick[9:8])
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= (stall_tick[2:0] < 3'd5);
    endcase
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.word_valid = word_valid_o;
      got.word_index = word_index_o;
      got.word_value = word_value_o;
      got.sync_found = sync_found_o;
      got.frame_done = frame_done_o;
      tracker.check_word(got);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("FAIL sync_word_frame_deframer");
    $finish;
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        gap = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        gap = $urandom_range(10, 20);
      end else begin
        gap = $urandom_range(1, 4);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.note_byte(b);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_word(input logic [WordW-1:0] w);
    for (int i = 3; i >= 0; i--) begin
      send_byte(w[i*8 +: 8]);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [WordW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_register(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_frame(input int kind);
    int n_words;
    int n_bytes;
    n_words = (tracker.words_per_frame == 0) ? 1 : int'(tracker.words_per_frame);
    if (kind <= 6) begin
      repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
      send_word(tracker.sync_word);
      repeat (n_words) send_word($urandom);
    end else if (kind == 7) begin
      send_word(tracker.sync_word);
      n_bytes = $urandom_range(0, 4 * n_words - 1);
      repeat (n_bytes) send_byte(8'($urandom_range(0, 255)));
    end else if (kind == 8) begin
      send_word(tracker.sync_word ^ (32'd1 << $urandom_range(0, 31)));
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 10)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int         phase;
    logic [3:0] words_sel;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_SYNC_WORD;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    rx_byte_i  = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_word(SyncWordReset);
    send_word(32'h00FF_00FF);
    drain();
    write_reg(CFG_PAYLOAD_WORDS, 32'd0);
    send_word(32'hFFFF_FFFF);
    drain();
    write_reg(CFG_SYNC_WORD, 32'hFFFF_FFFF);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0001);
    drain();
    write_reg(CFG_SYNC_WORD, 32'd0);
    repeat (3) send_byte(8'h00);
    drain();
    write_reg(CFG_SYNC_WORD, 32'h0000_00AB);
    send_byte(8'hAB);

    phase = 0;
    while (bytes_sent < ByteTarget) begin
      drain();
      case ($urandom_range(0, 5))
        0: ;
        1: write_reg(CFG_SYNC_WORD, ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : $urandom);
        2: write_reg(CFG_PAYLOAD_WORDS, $urandom_range(0, 15));
        default: begin
          case ($urandom_range(0, 7))
            0: write_reg(CFG_SYNC_WORD, 32'd0);
            1: write_reg(CFG_SYNC_WORD, 32'hFFFF_FFFF);
            default: write_reg(CFG_SYNC_WORD, $urandom);
          endcase
          case ($urandom_range(0, 7))
            0: words_sel = 4'd0;
            1: words_sel = 4'd15;
            default: words_sel = 4'($urandom_range(1, 4));
          endcase
          write_reg(CFG_PAYLOAD_WORDS, 32'(words_sel));
        end
      endcase
      if (phase % 8 == 3) begin
        write_reg(CFG_PAYLOAD_WORDS, 32'd15);
      end else if (phase % 8 == 5) begin
        write_reg(CFG_PAYLOAD_WORDS, 32'd1);
      end
      repeat ($urandom_range(1, 4)) send_frame($urandom_range(0, 9));
      phase++;
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (tracker.mismatches == 0 && tracker.expected_words.size() == 0) begin
      $display("PASS sync_word_frame_deframer");
    end else begin
      $display("FAIL sync_word_frame_deframer");
    end
    $finish;
  end

endmodule
